### rtl/core/lkvc_pkg.sv
`timescale 1ns / 1ps

package lkvc_pkg;

  localparam int unsigned KeyW = 32;
  localparam int unsigned ValW = 32;
  localparam int unsigned CapW = 5;

  localparam logic [CapW-1:0] CapReset = CapW'(16);
  localparam logic [ValW-1:0] MissValue = '1;

  localparam logic OpGet = 1'b0;
  localparam logic OpSet = 1'b1;

  typedef struct packed {
    logic            op;
    logic [KeyW-1:0] key;
    logic [ValW-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic            found;
    logic [ValW-1:0] read_value;
  } out_item_t;

  // control broadcast from the sequencer to every cell
  typedef struct packed {
    logic            cmp;  // compare cycle
    logic            upd;  // update cycle
    logic            hit;  // key present (from registered matches)
    logic            ins;  // set of a new key
    logic [KeyW-1:0] key;
  } cell_ctrl_t;

endpackage

### rtl/core/lru_key_value_cache_top.sv
`timescale 1ns / 1ps

// LRU key/value cache, fully associative, kept in recency order.
//
// Input channel: an item (op, key, value) is taken at a clock edge where
// start is high and busy is low. op selects get (lookup and refresh) or
// set (insert or update).
// Result channel: each get yields one item on result_o, valid for exactly
// one cycle while result_valid_o is high; a set yields nothing. The
// receiver cannot stall, so results never back up.
// Operation: a parallel compare in every cell (StCmp), then a shift of the
// cell chain toward the tail (StUpd), which puts the entry at the front.
// A new item can be accepted during the update of the previous one; busy
// is high only during the compare cycle. Results register in StUpd.
// Config: cfg_data_i writes the capacity (0 acts as 1, above MAX_ENTRIES
// saturates) and empties the table. Accepted whenever no item is in
// flight.
// Reset: table empty, capacity 16. Entry storage is not cleared; only
// positions below the fill count are ever compared.
module lru_key_value_cache_top #(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  lkvc_pkg::in_item_t          in_i,
  output logic                        result_valid_o,
  output lkvc_pkg::out_item_t         result_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [lkvc_pkg::CapW-1:0]   cfg_data_i
);
  import lkvc_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned CmpW = (CntW > CapW) ? CntW : CapW;

  typedef enum logic [1:0] {
    StIdle,
    StCmp,
    StUpd
  } state_e;

  state_e          state_q;
  in_item_t        item_q;
  out_item_t       result_q;
  logic            result_valid_q;
  logic [CapW-1:0] capacity_q;
  logic [CntW-1:0] fill_q;

  logic [CntW-1:0] cap_eff;
  logic [CntW-1:0] new_fill;
  logic            accept;
  cell_ctrl_t      ctrl;

  // chain wiring: data flows toward the tail, match/hit chains toward the head
  logic [MAX_ENTRIES-1:0][KeyW-1:0] cell_key;
  logic [MAX_ENTRIES-1:0][ValW-1:0] cell_val;
  logic [MAX_ENTRIES:0]             behind;
  logic [MAX_ENTRIES:0][ValW-1:0]   hitval;
  logic [ValW-1:0]                  head_val;

  assign busy           = (state_q == StCmp);
  assign accept         = start & ~busy;
  assign cfg_ready_o    = (state_q == StIdle);
  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

  // effective capacity: clamp to 1..MAX_ENTRIES
  always_comb begin
    priority if (capacity_q == '0) begin
      cap_eff = CntW'(1);
    end else if (CmpW'(capacity_q) > CmpW'(MAX_ENTRIES)) begin
      cap_eff = CntW'(MAX_ENTRIES);
    end else begin
      cap_eff = CntW'(capacity_q);
    end
  end

  assign new_fill = (fill_q < cap_eff) ? fill_q + CntW'(1) : fill_q;

  assign ctrl.cmp = (state_q == StCmp);
  assign ctrl.upd = (state_q == StUpd);
  assign ctrl.hit = behind[0];
  assign ctrl.ins = (item_q.op == OpSet) & ~behind[0];
  assign ctrl.key = item_q.key;

  // front entry: set stores the new value, a get hit refreshes the old one
  assign head_val = (item_q.op == OpSet) ? item_q.value : hitval[0];

  assign behind[MAX_ENTRIES] = 1'b0;
  assign hitval[MAX_ENTRIES] = '0;

  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    logic [KeyW-1:0] prev_key;
    logic [ValW-1:0] prev_val;

    if (g == 0) begin : g_head
      assign prev_key = item_q.key;
      assign prev_val = head_val;
    end else begin : g_body
      assign prev_key = cell_key[g-1];
      assign prev_val = cell_val[g-1];
    end

    lkvc_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .valid_i    (CntW'(g) < fill_q),
      .lt_fill_i  (CntW'(g) < new_fill),
      .prev_key_i (prev_key),
      .prev_val_i (prev_val),
      .key_o      (cell_key[g]),
      .val_o      (cell_val[g]),
      .behind_i   (behind[g+1]),
      .behind_o   (behind[g]),
      .hitval_i   (hitval[g+1]),
      .hitval_o   (hitval[g])
    );
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_i;
    end
  end

  // sequencer, result register, fill count and capacity
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= StIdle;
      result_valid_q <= 1'b0;
      result_q       <= '0;
      capacity_q     <= CapReset;
      fill_q         <= '0;
    end else begin
      result_valid_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (accept) begin
            state_q <= StCmp;
          end
        end
        StCmp: begin
          state_q <= StUpd;
        end
        StUpd: begin
          state_q <= accept ? StCmp : StIdle;
          if (item_q.op == OpGet) begin
            result_valid_q      <= 1'b1;
            result_q.found      <= behind[0];
            result_q.read_value <= behind[0] ? hitval[0] : MissValue;
          end else if (!behind[0]) begin
            fill_q <= new_fill;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
      if (cfg_valid_i && cfg_ready_o) begin
        capacity_q <= cfg_data_i;
        fill_q     <= '0;
      end
    end
  end

endmodule

### rtl/core/lkvc_cell.sv
`timescale 1ns / 1ps

module lkvc_cell (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  lkvc_pkg::cell_ctrl_t    ctrl_i,
  input  logic                    valid_i,    // position below fill count
  input  logic                    lt_fill_i,  // position below fill count after insert
  input  logic [lkvc_pkg::KeyW-1:0] prev_key_i,
  input  logic [lkvc_pkg::ValW-1:0] prev_val_i,
  output logic [lkvc_pkg::KeyW-1:0] key_o,
  output logic [lkvc_pkg::ValW-1:0] val_o,
  input  logic                    behind_i,   // match at a later position
  output logic                    behind_o,
  input  logic [lkvc_pkg::ValW-1:0] hitval_i,
  output logic [lkvc_pkg::ValW-1:0] hitval_o
);
  import lkvc_pkg::*;

  logic [KeyW-1:0] key_q;
  logic [ValW-1:0] val_q;
  logic            match_q;
  logic            shift_en;

  assign behind_o = behind_i | match_q;
  assign hitval_o = hitval_i | (match_q ? val_q : '0);
  assign key_o    = key_q;
  assign val_o    = val_q;

  // take the neighbor's entry when this position lies at or before the hole
  assign shift_en = ctrl_i.upd &
                    ((ctrl_i.hit & behind_o) | (ctrl_i.ins & lt_fill_i));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else if (ctrl_i.cmp) begin
      match_q <= valid_i & (key_q == ctrl_i.key);
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_en) begin
      key_q <= prev_key_i;
      val_q <= prev_val_i;
    end
  end

endmodule
